/* rtl/core/cbtm_pkg.sv */
// ----------------------------------------------------------------------------
// cbtm_pkg
// shared codes and default sizes for the counted binary trie best mask match
// ----------------------------------------------------------------------------
`default_nettype none
package cbtm_pkg;
    // fixed field widths of the ports
    localparam int KEY_W   = 30;
    localparam int COUNT_W = 11;

    // default sizing
    localparam int KEY_BITS_DEF = 30;
    localparam int CAPACITY_DEF = 1024;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;
endpackage
`default_nettype wire

/* rtl/core/counted_binary_trie_best_mask_match.sv */
// ----------------------------------------------------------------------------
// counted_binary_trie_best_mask_match
// multiset of keys in a counted binary trie with insert, remove, best mask query
// ----------------------------------------------------------------------------
// operations: clear, full-by-count insert and empty query go straight to the
//   done state and the output register; insert and remove make a check walk
//   and an update walk, and a query makes one walk that reads the wanted child
//   first where it exists; one beat is taken at a time, only in idle, and the
//   node memory walk reads one node per trie level (a fetch state, then a step state)
// reset: root links, next free node and key total reset at once, no sweep
// ----------------------------------------------------------------------------
`default_nettype none
module counted_binary_trie_best_mask_match #(
    parameter int KEY_BITS = cbtm_pkg::KEY_BITS_DEF,
    parameter int CAPACITY = cbtm_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [cbtm_pkg::KEY_W-1:0]    i_key_value,
    input  wire logic [cbtm_pkg::KEY_W-1:0]    i_mask_value,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic [cbtm_pkg::KEY_W-1:0]         o_found_key,
    output logic [cbtm_pkg::COUNT_W-1:0]       o_stored_count
);
    // node pool: root plus one node per key bit per stored key
    localparam int NODE_COUNT = 1 + KEY_BITS * CAPACITY;
    localparam int NW = $clog2(NODE_COUNT);       // node index
    localparam int FW = $clog2(NODE_COUNT + 1);   // next free can reach the pool size
    localparam int CW = $clog2(CAPACITY + 1);     // per-node key count
    localparam int LW = $clog2(KEY_BITS + 1);     // trie level

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // node memories, addressed by the current node
    logic [2*NW-1:0] mem_links [NODE_COUNT];
    logic [CW-1:0]   mem_cnt   [NODE_COUNT];
    logic [2*NW-1:0] r_rd_links;
    logic [CW-1:0]   r_rd_cnt;
    logic            wr_en;
    logic [2*NW-1:0] wr_links;
    logic [CW-1:0]   wr_cnt;

    // control state
    logic [1:0]          r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic                r_upd, n_upd;      // second walk of insert or remove
    logic                r_tent, n_tent;    // query: node under test is the wanted child
    logic                r_new, n_new;      // insert: current node freshly allocated
    logic [NW-1:0]       r_cur, n_cur;
    logic [NW-1:0]       r_alt, n_alt;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [FW-1:0]       r_free, n_free;
    logic [CW-1:0]       r_total, n_total;
    logic [NW-1:0]       r_root0, n_root0;
    logic [NW-1:0]       r_root1, n_root1;
    logic                r_out_vld, n_out_vld;

    // payload
    logic [KEY_BITS-1:0] r_kin, n_kin;      // key as received, reloaded for the update walk
    logic [KEY_BITS-1:0] r_key, n_key;      // key shifted, top bit is the current level
    logic [KEY_BITS-1:0] r_mask, n_mask;
    logic [KEY_BITS-1:0] r_best, n_best;
    logic [1:0]          r_res, n_res;
    logic [1:0]          r_status, n_status;
    logic [cbtm_pkg::KEY_W-1:0]   r_found, n_found;
    logic [cbtm_pkg::COUNT_W-1:0] r_count, n_count;

    // step helpers
    logic          in_beat;
    logic [31:0]   key32, mask32, best32, total32;
    logic [NW-1:0] lk0, lk1, nxt_d, want_lk, alt_lk, child;
    logic [CW-1:0] cnt;
    logic          dir, want, at_leaf;
    logic [LW-1:0] missing;
    logic [FW:0]   pool_need;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_beat        = i_in_valid && !o_in_stall;
    assign o_out_valid    = r_out_vld;
    assign o_status       = r_status;
    assign o_found_key    = r_found;
    assign o_stored_count = r_count;

    assign key32   = 32'(i_key_value);
    assign mask32  = 32'(i_mask_value);
    assign best32  = 32'(r_best);
    assign total32 = 32'(r_total);

    // memory read every cycle at the current node, write at the same node
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_links[r_cur] <= wr_links;
            mem_cnt[r_cur]   <= wr_cnt;
        end
        r_rd_links <= mem_links[r_cur];
        r_rd_cnt   <= mem_cnt[r_cur];
    end

    // effective view of the current node: root links live in registers,
    // a fresh node has no links and no keys yet
    always_comb begin
        if (r_new) begin
            lk0 = '0;
            lk1 = '0;
            cnt = '0;
        end else if (r_cur == '0) begin
            lk0 = r_root0;
            lk1 = r_root1;
            cnt = r_rd_cnt;
        end else begin
            lk0 = r_rd_links[NW-1:0];
            lk1 = r_rd_links[2*NW-1:NW];
            cnt = r_rd_cnt;
        end
    end

    assign dir       = r_key[KEY_BITS-1];
    assign nxt_d     = dir ? lk1 : lk0;
    assign want      = !r_mask[KEY_BITS-1];
    assign want_lk   = want ? lk1 : lk0;
    assign alt_lk    = want ? lk0 : lk1;
    assign at_leaf   = (r_lvl == LW'(KEY_BITS));
    assign missing   = LW'(KEY_BITS) - r_lvl;
    assign pool_need = (FW+1)'(r_free) + (FW+1)'(missing);
    assign child     = (nxt_d == '0) ? r_free[NW-1:0] : nxt_d;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_upd     = r_upd;
        n_tent    = r_tent;
        n_new     = r_new;
        n_cur     = r_cur;
        n_alt     = r_alt;
        n_lvl     = r_lvl;
        n_free    = r_free;
        n_total   = r_total;
        n_root0   = r_root0;
        n_root1   = r_root1;
        n_out_vld = r_out_vld;
        n_kin     = r_kin;
        n_key     = r_key;
        n_mask    = r_mask;
        n_best    = r_best;
        n_res     = r_res;
        n_status  = r_status;
        n_found   = r_found;
        n_count   = r_count;
        wr_en     = 1'b0;
        wr_links  = {lk1, lk0};
        wr_cnt    = cnt;

        // result beat taken downstream
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_op    = i_operation;
                    n_kin   = key32[KEY_BITS-1:0];
                    n_key   = key32[KEY_BITS-1:0];
                    n_mask  = mask32[KEY_BITS-1:0];
                    n_best  = '0;
                    n_res   = cbtm_pkg::ST_OK;
                    n_cur   = '0;
                    n_lvl   = '0;
                    n_upd   = 1'b0;
                    n_tent  = 1'b0;
                    n_new   = 1'b0;
                    n_state = S_FETCH;
                    case (i_operation)
                        cbtm_pkg::OP_INSERT: begin
                            if (r_total >= CW'(CAPACITY)) begin
                                n_res   = cbtm_pkg::ST_FULL;
                                n_state = S_DONE;
                            end
                        end
                        cbtm_pkg::OP_QUERY: begin
                            if (r_total == '0) begin
                                n_res   = cbtm_pkg::ST_EMPTY;
                                n_state = S_DONE;
                            end
                        end
                        cbtm_pkg::OP_CLEAR: begin
                            n_root0 = '0;
                            n_root1 = '0;
                            n_free  = FW'(1);
                            n_total = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            // remove starts its check walk
                        end
                    endcase
                end
            end

            S_FETCH: begin
                n_state = S_STEP;
            end

            S_STEP: begin
                n_state = S_FETCH;
                case (r_op)
                    cbtm_pkg::OP_INSERT: begin
                        if (!r_upd) begin
                            // check walk: find how many nodes the path still needs
                            if (at_leaf || nxt_d == '0) begin
                                if (pool_need > (FW+1)'(NODE_COUNT)) begin
                                    n_res   = cbtm_pkg::ST_FULL;
                                    n_state = S_DONE;
                                end else begin
                                    n_upd = 1'b1;
                                    n_cur = '0;
                                    n_lvl = '0;
                                    n_key = r_kin;
                                end
                            end else begin
                                n_cur = nxt_d;
                                n_lvl = r_lvl + LW'(1);
                                n_key = r_key << 1;
                            end
                        end else begin
                            // update walk: raise counts, allocate missing children
                            wr_en  = (r_cur != '0);
                            wr_cnt = cnt + CW'(1);
                            if (at_leaf) begin
                                n_total = r_total + CW'(1);
                                n_state = S_DONE;
                            end else begin
                                if (dir) begin
                                    wr_links = {child, lk0};
                                end else begin
                                    wr_links = {lk1, child};
                                end
                                if (r_cur == '0) begin
                                    if (dir) begin
                                        n_root1 = child;
                                    end else begin
                                        n_root0 = child;
                                    end
                                end
                                if (nxt_d == '0) begin
                                    n_free = r_free + FW'(1);
                                end
                                n_new = (nxt_d == '0);
                                n_cur = child;
                                n_lvl = r_lvl + LW'(1);
                                n_key = r_key << 1;
                            end
                        end
                    end

                    cbtm_pkg::OP_REMOVE: begin
                        if (!r_upd) begin
                            // check walk: path must exist and leaf must hold keys
                            if (at_leaf) begin
                                if (cnt == '0) begin
                                    n_res   = cbtm_pkg::ST_ABSENT;
                                    n_state = S_DONE;
                                end else begin
                                    n_upd = 1'b1;
                                    n_cur = '0;
                                    n_lvl = '0;
                                    n_key = r_kin;
                                end
                            end else if (nxt_d == '0) begin
                                n_res   = cbtm_pkg::ST_ABSENT;
                                n_state = S_DONE;
                            end else begin
                                n_cur = nxt_d;
                                n_lvl = r_lvl + LW'(1);
                                n_key = r_key << 1;
                            end
                        end else begin
                            // update walk: lower counts along the path
                            wr_en  = (r_cur != '0);
                            wr_cnt = cnt - CW'(1);
                            if (at_leaf) begin
                                n_total = r_total - CW'(1);
                                n_state = S_DONE;
                            end else begin
                                n_cur = nxt_d;
                                n_lvl = r_lvl + LW'(1);
                                n_key = r_key << 1;
                            end
                        end
                    end

                    cbtm_pkg::OP_QUERY: begin
                        if (r_tent) begin
                            // wanted child read back: keep it if it holds keys
                            n_tent = 1'b0;
                            n_lvl  = r_lvl + LW'(1);
                            n_mask = r_mask << 1;
                            if (cnt == '0) begin
                                n_cur  = r_alt;
                                n_best = {r_best[KEY_BITS-2:0], !want};
                            end else begin
                                n_best = {r_best[KEY_BITS-2:0], want};
                            end
                        end else if (at_leaf) begin
                            n_state = S_DONE;
                        end else if (want_lk == '0) begin
                            n_cur  = alt_lk;
                            n_best = {r_best[KEY_BITS-2:0], !want};
                            n_lvl  = r_lvl + LW'(1);
                            n_mask = r_mask << 1;
                        end else begin
                            n_cur  = want_lk;
                            n_alt  = alt_lk;
                            n_tent = 1'b1;
                        end
                    end

                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_DONE: begin
                // load the output register once it is free
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld = 1'b1;
                    n_status  = r_res;
                    n_found   = (r_op == cbtm_pkg::OP_QUERY && r_res == cbtm_pkg::ST_OK)
                              ? best32[cbtm_pkg::KEY_W-1:0] : '0;
                    n_count   = total32[cbtm_pkg::COUNT_W-1:0];
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_root0   <= '0;
            r_root1   <= '0;
            r_free    <= FW'(1);
            r_total   <= '0;
            r_upd     <= 1'b0;
            r_tent    <= 1'b0;
            r_new     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_root0   <= n_root0;
            r_root1   <= n_root1;
            r_free    <= n_free;
            r_total   <= n_total;
            r_upd     <= n_upd;
            r_tent    <= n_tent;
            r_new     <= n_new;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_cur    <= n_cur;
        r_alt    <= n_alt;
        r_lvl    <= n_lvl;
        r_kin    <= n_kin;
        r_key    <= n_key;
        r_mask   <= n_mask;
        r_best   <= n_best;
        r_res    <= n_res;
        r_status <= n_status;
        r_found  <= n_found;
        r_count  <= n_count;
    end
endmodule
`default_nettype wire

/* rtl/core/cbtm_checker.sv */
// ----------------------------------------------------------------------------
// cbtm_checker
// port-level checks on the result channel of the trie block
// ----------------------------------------------------------------------------
`default_nettype none
module cbtm_checker #(
    parameter int CAPACITY = cbtm_pkg::CAPACITY_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [1:0]                    o_status,
    input wire logic [cbtm_pkg::KEY_W-1:0]    o_found_key,
    input wire logic [cbtm_pkg::COUNT_W-1:0]  o_stored_count
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_found_key) && $stable(o_stored_count))
        else $error("stalled result beat changed");

    // found key only on an ok result
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != cbtm_pkg::ST_OK |-> o_found_key == '0)
        else $error("found key set on a failed operation");

    // empty query means nothing is stored
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == cbtm_pkg::ST_EMPTY |-> o_stored_count == '0)
        else $error("empty status with keys stored");

    // count never passes capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_stored_count) <= CAPACITY)
        else $error("stored count above capacity");
endmodule

bind counted_binary_trie_best_mask_match cbtm_checker #(.CAPACITY(CAPACITY)) u_cbtm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_found_key    (o_found_key),
    .o_stored_count (o_stored_count)
);
`default_nettype wire

/* tb/sv/cbtm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtm_scoreboard
// watches both channels of the trie block, keeps its own trie copy to work out
// each expected result beat, and compares the results in order
// ----------------------------------------------------------------------------
module cbtm_scoreboard (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [1:0]                       i_operation,
    input  logic [cbtm_pkg::KEY_W-1:0]       i_key_value,
    input  logic [cbtm_pkg::KEY_W-1:0]       i_mask_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [1:0]                       i_status,
    input  logic [cbtm_pkg::KEY_W-1:0]       i_found_key,
    input  logic [cbtm_pkg::COUNT_W-1:0]     i_stored_count,
    output int                               o_mismatches,
    output int                               o_results_due
);
    import cbtm_pkg::*;

    localparam int NODES = 1 + KEY_BITS_DEF * CAPACITY_DEF;

    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   found;
        logic [COUNT_W-1:0] count;
    } t_trie_result;

    int unsigned  child [NODES][2];
    int unsigned  through [NODES];
    int unsigned  free_node;
    int unsigned  held_keys;
    t_trie_result due_results [$];

    function automatic logic [1:0] trie_insert(input logic [KEY_W-1:0] key);
        int unsigned node;
        int unsigned nxt;
        int unsigned missing;
        int b;
        node = 0;
        missing = 0;
        if (held_keys >= CAPACITY_DEF) return ST_FULL;
        for (b = KEY_BITS_DEF - 1; b >= 0; b--) begin
            nxt = child[node][key[b]];
            if (nxt == 0) begin
                missing = b + 1;
                break;
            end
            node = nxt;
        end
        if (free_node + missing > NODES) return ST_FULL;
        node = 0;
        through[0]++;
        for (b = KEY_BITS_DEF - 1; b >= 0; b--) begin
            nxt = child[node][key[b]];
            if (nxt == 0) begin
                nxt = free_node++;
                child[nxt][0] = 0;
                child[nxt][1] = 0;
                through[nxt] = 0;
                child[node][key[b]] = nxt;
            end
            node = nxt;
            through[node]++;
        end
        held_keys++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] trie_remove(input logic [KEY_W-1:0] key);
        int unsigned node;
        int b;
        node = 0;
        for (b = KEY_BITS_DEF - 1; b >= 0; b--) begin
            node = child[node][key[b]];
            if (node == 0) return ST_ABSENT;
        end
        if (through[node] == 0) return ST_ABSENT;
        node = 0;
        through[0]--;
        for (b = KEY_BITS_DEF - 1; b >= 0; b--) begin
            node = child[node][key[b]];
            through[node]--;
        end
        held_keys--;
        return ST_OK;
    endfunction

    // greedy walk: take the branch where the mask bit is clear when it holds keys
    function automatic logic [1:0] trie_best(input logic [KEY_W-1:0] mask,
                                             output logic [KEY_W-1:0] best);
        int unsigned node;
        int unsigned nxt;
        logic want;
        int b;
        node = 0;
        best = '0;
        if (held_keys == 0) return ST_EMPTY;
        for (b = KEY_BITS_DEF - 1; b >= 0; b--) begin
            want = ~mask[b];
            nxt = child[node][want];
            if (nxt != 0 && through[nxt] > 0) begin
                best[b] = want;
            end else begin
                best[b] = ~want;
                nxt = child[node][~want];
            end
            node = nxt;
        end
        return ST_OK;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch at %0t: %0s got %0h expected %0h", $realtime, what, got, want);
        o_mismatches++;
    endtask

    initial begin
        o_mismatches = 0;
        child[0][0] = 0;
        child[0][1] = 0;
        through[0] = 0;
        free_node = 1;
        held_keys = 0;
    end

    assign o_results_due = due_results.size();

    always @(posedge i_clk) begin
        t_trie_result r;
        t_trie_result e;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            r = '0;
            case (i_operation)
                OP_INSERT: r.status = trie_insert(i_key_value);
                OP_REMOVE: r.status = trie_remove(i_key_value);
                OP_QUERY:  r.status = trie_best(i_mask_value, r.found);
                default: begin
                    child[0][0] = 0;
                    child[0][1] = 0;
                    through[0] = 0;
                    free_node = 1;
                    held_keys = 0;
                end
            endcase
            r.count = held_keys[COUNT_W-1:0];
            due_results = {due_results, r};
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                report("unexpected beat", 0, 0);
            end else begin
                e = due_results.pop_front();
                if (i_status !== e.status) report("status", i_status, e.status);
                if (i_found_key !== e.found) report("found_key", i_found_key, e.found);
                if (i_stored_count !== e.count)
                    report("stored_count", i_stored_count, e.count);
            end
        end
    end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the trie block: directed corner beats, then a
// random mix over a small key pool
// ----------------------------------------------------------------------------
module tb;
    import cbtm_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_operation;
    logic [KEY_W-1:0]     i_key_value;
    logic [KEY_W-1:0]     i_mask_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_status;
    logic [KEY_W-1:0]     o_found_key;
    logic [COUNT_W-1:0]   o_stored_count;

    int mismatches;
    int results_due;
    int beats_sent;
    bit quiet_phase;      // no idling on either side near the end

    localparam logic [KEY_W-1:0] ALL_ONES = '1;

    counted_binary_trie_best_mask_match dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_key_value    (i_key_value),
        .i_mask_value   (i_mask_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_key    (o_found_key),
        .o_stored_count (o_stored_count)
    );

    cbtm_scoreboard u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_key_value    (i_key_value),
        .i_mask_value   (i_mask_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_found_key    (o_found_key),
        .i_stored_count (o_stored_count),
        .o_mismatches   (mismatches),
        .o_results_due  (results_due)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #60_000_000;
        $display("counted_binary_trie_best_mask_match regression: fail");
        $finish;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'($urandom);
    endfunction

    // offer one beat on the falling edge, hold it until the block takes it
    task automatic send_beat(input logic [1:0] op, input logic [KEY_W-1:0] key,
                             input logic [KEY_W-1:0] mask);
        int gap;
        gap = (!quiet_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_key_value  <= key;
        i_mask_value <= mask;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    // receiver: random stall bursts, one long hold-off so the block backs up
    initial begin
        bit held_off;
        held_off = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held_off && beats_sent >= 40) begin
                held_off = 1;
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (quiet_phase) begin
                @(negedge i_clk) i_out_stall <= 1'b0;
            end else begin
                @(negedge i_clk) i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] key_pool [16];
        logic [KEY_W-1:0] k;
        int waited;
        int pick;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = OP_CLEAR;
        i_key_value  = '0;
        i_mask_value = '0;
        beats_sent   = 0;
        quiet_phase  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed corners: empty query, absent removal, extreme keys and masks
        send_beat(OP_QUERY, rand_key(), '0);
        send_beat(OP_REMOVE, ALL_ONES, '0);
        send_beat(OP_INSERT, '0, ALL_ONES);
        send_beat(OP_QUERY, ALL_ONES, ALL_ONES);
        send_beat(OP_INSERT, ALL_ONES, '0);
        send_beat(OP_INSERT, ALL_ONES, '0);
        send_beat(OP_QUERY, '0, '0);
        send_beat(OP_QUERY, '0, ALL_ONES);
        send_beat(OP_REMOVE, ALL_ONES, '0);
        send_beat(OP_QUERY, '0, '0);
        send_beat(OP_REMOVE, ALL_ONES, '0);
        send_beat(OP_QUERY, '0, '0);
        send_beat(OP_INSERT, 30'h2AAA_AAAA, '0);
        send_beat(OP_INSERT, 30'h1555_5555, '0);
        send_beat(OP_QUERY, '0, 30'h2AAA_AAAA);
        send_beat(OP_QUERY, '0, 30'h1555_5555);
        send_beat(OP_REMOVE, 30'h2AAA_AAAB, '0);  // shares all but the last level
        send_beat(OP_CLEAR, ALL_ONES, ALL_ONES);
        send_beat(OP_QUERY, '0, '0);
        send_beat(OP_REMOVE, '0, '0);

        // random mix; keys mostly from a small pool so removes and queries hit
        foreach (key_pool[i]) key_pool[i] = rand_key();
        for (int n = 0; n < 880; n++) begin
            if (n == 720) quiet_phase = 1;
            pick = $urandom_range(0, 99);
            k = ($urandom_range(0, 4) == 0) ? rand_key() : key_pool[$urandom_range(0, 15)];
            if (pick < 40)      send_beat(OP_INSERT, k, rand_key());
            else if (pick < 65) send_beat(OP_REMOVE, k, rand_key());
            else if (pick < 98) send_beat(OP_QUERY, rand_key(), rand_key());
            else                send_beat(OP_CLEAR, k, rand_key());
        end
        @(negedge i_clk) i_in_valid <= 1'b0;

        // drain, then wait on for stray beats
        waited = 0;
        while (results_due != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && results_due == 0) begin
            $display("counted_binary_trie_best_mask_match regression: pass");
        end else begin
            $display("counted_binary_trie_best_mask_match regression: fail");
        end
        $finish;
    end
endmodule

/* counted_binary_trie_best_mask_match.f */
rtl/core/cbtm_pkg.sv
rtl/core/counted_binary_trie_best_mask_match.sv
rtl/core/cbtm_checker.sv
tb/sv/cbtm_checker.sv
tb/sv/tb.sv
